// File: sv/rrc_pkg.sv
// shared types and constants for the range remap chain
package rrc_pkg;

    localparam int ACTION_W   = 2;
    localparam int STAGE_W    = 3;
    localparam int SLOT_W     = 6;
    localparam int WORD_W     = 32;
    localparam int SPAN_W     = 33;
    localparam int IN_DATA_W  = 144;
    localparam int OUT_DATA_W = 64;

    typedef enum logic [ACTION_W-1:0] {
        ACT_LOAD  = 2'd0,
        ACT_XLATE = 2'd1,
        ACT_CLEAR = 2'd2
    } action_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic load;
        logic sweep_start;
        logic sweep_step;
        logic scan_start;
        logic scan_step;
        logic stage_next;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic addr_last;
        logic addr_zero;
        logic slot_last;
        logic pipe_busy;
        logic out_hold;
    } stat_t;

endpackage

// File: sv/rrc_datapath.sv
// entry memory, compare pipeline, running minimum and output register
module rrc_datapath #(
    parameter int STAGES     = 8,
    parameter int ENTRIES    = 64,
    parameter int VALUE_BITS = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  rrc_pkg::cmd_t                cmd,
    output rrc_pkg::stat_t               stat,
    input  logic [rrc_pkg::STAGE_W-1:0]  in_stage,
    input  logic [rrc_pkg::SLOT_W-1:0]   in_slot,
    input  logic [rrc_pkg::WORD_W-1:0]   in_dest_start,
    input  logic [rrc_pkg::WORD_W-1:0]   in_src_start,
    input  logic [rrc_pkg::SPAN_W-1:0]   in_span,
    input  logic [rrc_pkg::WORD_W-1:0]   in_query,
    input  logic                         out_ready,
    output logic                         out_valid,
    output logic [rrc_pkg::WORD_W-1:0]   out_mapped,
    output logic [rrc_pkg::WORD_W-1:0]   out_lowest
);
    import rrc_pkg::*;

    localparam int VB    = VALUE_BITS;
    localparam int DEPTH = STAGES * ENTRIES;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SLW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int WW    = 1 + SPAN_W + 2 * VB;
    localparam int CW    = (VB > SPAN_W) ? VB : SPAN_W;
    localparam int LIW   = STAGE_W + SLOT_W + $clog2(ENTRIES + 1) + 1;

    logic [WW-1:0]     mem [DEPTH];
    logic [WW-1:0]     rdata_reg;

    logic [AW-1:0]     addr_reg;
    logic [SLW-1:0]    slot_reg;
    logic              p0_valid_reg;
    logic              p1_valid_reg;
    logic              hit_reg;
    logic              out_valid_reg;
    logic [VB-1:0]     min_reg;
    logic [VB-1:0]     min_next;

    logic [VB-1:0]     v_reg;
    logic [VB-1:0]     res_reg;
    logic [VB-1:0]     diff_reg;
    logic              ok1_reg;
    logic [SPAN_W-1:0] span1_reg;
    logic [VB-1:0]     dest1_reg;
    logic [WORD_W-1:0] mapped_reg;
    logic [WORD_W-1:0] lowest_reg;

    logic [LIW-1:0]    load_idx;
    logic              load_ok;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [WW-1:0]     wr_data;
    logic              rd_valid;
    logic [SPAN_W-1:0] rd_span;
    logic [VB-1:0]     rd_src;
    logic [VB-1:0]     rd_dest;
    logic [VB:0]       diff_full;
    logic              in_range;
    logic [VB-1:0]     sum;
    logic [AW-1:0]     addr_inc;

    // write port: single entry load or invalidating sweep
    assign load_idx = LIW'(in_stage) * LIW'(ENTRIES) + LIW'(in_slot);
    assign load_ok  = (32'(in_stage) < 32'(STAGES)) && (32'(in_slot) < 32'(ENTRIES));
    assign wr_en    = (cmd.load && load_ok) || cmd.sweep_step;
    assign wr_addr  = cmd.sweep_step ? addr_reg : AW'(load_idx);
    assign wr_data  = cmd.sweep_step ? '0 :
                      {1'b1, in_span, VB'(in_src_start), VB'(in_dest_start)};

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.scan_step)
        begin
            rdata_reg <= mem[addr_reg];
        end
    end

    assign rd_valid  = rdata_reg[WW-1];
    assign rd_span   = rdata_reg[WW-2 -: SPAN_W];
    assign rd_src    = rdata_reg[2*VB-1 -: VB];
    assign rd_dest   = rdata_reg[VB-1:0];
    assign diff_full = {1'b0, v_reg} - {1'b0, rd_src};

    assign in_range  = p1_valid_reg && ok1_reg && !hit_reg &&
                       (CW'(diff_reg) < CW'(span1_reg));
    assign sum       = diff_reg + dest1_reg;
    assign min_next  = (v_reg < min_reg) ? v_reg : min_reg;
    assign addr_inc  = (addr_reg == AW'(DEPTH - 1)) ? '0 : addr_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg      <= '0;
            slot_reg      <= '0;
            p0_valid_reg  <= 1'b0;
            p1_valid_reg  <= 1'b0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            min_reg       <= '1;
        end
        else
        begin
            p0_valid_reg <= cmd.scan_step;
            p1_valid_reg <= p0_valid_reg;
            if (cmd.sweep_start)
            begin
                addr_reg <= '0;
                min_reg  <= '1;
            end
            else if (cmd.scan_start)
            begin
                addr_reg <= '0;
                slot_reg <= '0;
                hit_reg  <= 1'b0;
            end
            else if (cmd.sweep_step)
            begin
                addr_reg <= addr_inc;
            end
            else if (cmd.scan_step)
            begin
                addr_reg <= addr_inc;
                slot_reg <= (slot_reg == SLW'(ENTRIES - 1)) ? '0 : slot_reg + 1'b1;
            end
            if (in_range)
            begin
                hit_reg <= 1'b1;
            end
            else if (cmd.stage_next)
            begin
                hit_reg <= 1'b0;
            end
            if (cmd.finish)
            begin
                min_reg       <= min_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        diff_reg  <= diff_full[VB-1:0];
        ok1_reg   <= rd_valid && !diff_full[VB];
        span1_reg <= rd_span;
        dest1_reg <= rd_dest;
        if (cmd.scan_start)
        begin
            v_reg <= VB'(in_query);
        end
        else if (cmd.stage_next && hit_reg)
        begin
            v_reg <= res_reg;
        end
        if (in_range)
        begin
            res_reg <= sum;
        end
        if (cmd.finish)
        begin
            mapped_reg <= WORD_W'(v_reg);
            lowest_reg <= WORD_W'(min_next);
        end
    end

    assign stat.addr_last = (addr_reg == AW'(DEPTH - 1));
    assign stat.addr_zero = (addr_reg == '0);
    assign stat.slot_last = (slot_reg == SLW'(ENTRIES - 1));
    assign stat.pipe_busy = p0_valid_reg || p1_valid_reg;
    assign stat.out_hold  = out_valid_reg && !out_ready;

    assign out_valid  = out_valid_reg;
    assign out_mapped = mapped_reg;
    assign out_lowest = lowest_reg;

endmodule

// File: sv/rrc_ctrl.sv
// controller state machine for the range remap chain
module rrc_ctrl (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic [rrc_pkg::ACTION_W-1:0] in_action,
    output logic                         in_ready,
    input  rrc_pkg::stat_t               stat,
    output rrc_pkg::cmd_t                cmd
);
    import rrc_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_SWEEP;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    unique case (action_t'(in_action))
                        ACT_LOAD:
                        begin
                            cmd.load = 1'b1;
                        end
                        ACT_XLATE:
                        begin
                            cmd.scan_start = 1'b1;
                            state_next     = ST_SCAN;
                        end
                        ACT_CLEAR:
                        begin
                            cmd.sweep_start = 1'b1;
                            state_next      = ST_SWEEP;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_SWEEP:
            begin
                cmd.sweep_step = 1'b1;
                if (stat.addr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (stat.slot_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!stat.pipe_busy)
                begin
                    cmd.stage_next = 1'b1;
                    state_next     = stat.addr_zero ? ST_FINISH : ST_SCAN;
                end
            end
            ST_FINISH:
            begin
                if (!stat.out_hold)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: sv/range_remap_chain.sv
// top level of the range remap chain
// usage:
//   input words arrive on s_axis; tuser carries the action (load, translate,
//   clear), tdata carries stage, slot, dest_start, src_start, span and query.
//   a load writes one table entry in the cycle it is accepted.
//   a translate scans every entry of every stage, one memory read per cycle
//   while a stage is scanned, and puts one word (mapped, lowest) on m_axis.
//   the entry memory has a single read port, and the compare pipeline (read
//   data register, then difference register) drains at each stage boundary.
//   one translate is in flight at a time, so a new translate is not taken
//   until the last one has finished.
//   a clear sweeps the entry memory one entry per cycle with s_axis_tready
//   low; the same sweep runs right after reset.
//   the result sits in an output register; while it waits, loads and clears
//   and the start of a new translate are still taken, and a translate that
//   finishes holds until the register is free.
module range_remap_chain #(
    parameter int STAGES     = 8,
    parameter int ENTRIES    = 64,
    parameter int VALUE_BITS = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // stage, slot, dest_start, src_start, span, query, zero pad
    input  logic [rrc_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // action
    input  logic [rrc_pkg::ACTION_W-1:0]   s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // mapped, lowest
    output logic [rrc_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
    import rrc_pkg::*;

    cmd_t              cmd;
    stat_t             stat;
    logic [WORD_W-1:0] mapped;
    logic [WORD_W-1:0] lowest;

    rrc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_action (s_axis_tuser),
        .in_ready  (s_axis_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    rrc_datapath #(
        .STAGES     (STAGES),
        .ENTRIES    (ENTRIES),
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .in_stage      (s_axis_tdata[2:0]),
        .in_slot       (s_axis_tdata[8:3]),
        .in_dest_start (s_axis_tdata[40:9]),
        .in_src_start  (s_axis_tdata[72:41]),
        .in_span       (s_axis_tdata[105:73]),
        .in_query      (s_axis_tdata[137:106]),
        .out_ready     (m_axis_tready),
        .out_valid     (m_axis_tvalid),
        .out_mapped    (mapped),
        .out_lowest    (lowest)
    );

    assign m_axis_tdata = {lowest, mapped};

endmodule
